>>> src/hkoc_pkg.sv
// Package for the hashed key occurrence counter.
// Holds request and status codes, controller states and hash constants.
// No dependencies.
package hkoc_pkg;

    localparam int KEY_W        = 64;
    localparam int OUT_COUNT_W  = 32;
    localparam int OUT_SLOT_W   = 12;
    localparam int SUM_W        = 63;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 112;
    localparam int M_TUSER_W    = 2;

    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int          MIX_SHIFT_A = 30;
    localparam int          MIX_SHIFT_B = 27;
    localparam int          MIX_SHIFT_C = 31;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic {
        REQ_INSERT  = 1'b0,
        REQ_READOUT = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_NEW  = 2'd0,
        STATUS_INC  = 2'd1,
        STATUS_FULL = 2'd2,
        STATUS_READ = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_MIX,
        ST_PROBE,
        ST_SWEEP,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_SW_OUT
    } state_t;

endpackage

>>> src/hashed_key_occurrence_counter.sv
// Top level of the hashed key occurrence counter: hash, probe and sweep logic
// around one single-port table memory with a registered read port.
// Depends on hkoc_pkg.
//
//  channel | ports                          | fields (lowest bit up)
//  --------+--------------------------------+--------------------------------------
//  request | s_tvalid s_tready s_tdata s_tuser | tuser: req_type; tdata: key
//  result  | m_tvalid m_tready m_tdata m_tuser | tuser: status; tdata: occurrence_count,
//          |                                |   slot_index, triangle_sum, zero pad
//
// Insert: the hash passes ST_MUL and ST_MIX twice, then ST_PROBE decides at the home slot
// or reads the next slot for each further probe; the shared 32x32 multiplier runs the
// two 64-bit multiplies of the hash as three partial products each.
// Readout: one memory read per slot in ST_SWEEP, then ST_DRAIN1, ST_DRAIN2 and ST_SW_OUT.
// After reset a clearing pass writes zero to every slot before the first
// item is accepted. A stalled result holds; a new item may be accepted behind it
// and waits at its last step until the result register frees.
module hashed_key_occurrence_counter #(
    parameter int TABLE_DEPTH_LOG2 = 12,
    parameter int COUNT_WIDTH      = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hkoc_pkg::S_TDATA_W-1:0]  s_tdata,   // key[63:0]
    input  logic                            s_tuser,   // req_type[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // occurrence_count[31:0], slot_index[43:32], triangle_sum[106:44], zero[111:107]
    output logic [hkoc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [hkoc_pkg::M_TUSER_W-1:0]  m_tuser    // status[1:0]
);

    localparam int AW    = TABLE_DEPTH_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam int MEM_W = 1 + hkoc_pkg::KEY_W + COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [AW-1:0]          ADDR_LAST = {AW{1'b1}};

    logic [MEM_W-1:0] mem [DEPTH];
    logic [MEM_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [MEM_W-1:0] mem_wdata;

    hkoc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AW-1:0]    probe_reg, probe_next;
    logic [63:0]      key_reg, key_next;
    logic [63:0]      a_reg, a_next;
    logic [63:0]      acc_reg, acc_next;
    logic [1:0]       step_reg, step_next;
    logic             phase_reg, phase_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             tri_vld_reg;
    logic [63:0]      tri_reg;
    logic [hkoc_pkg::SUM_W-1:0] sum_reg, sum_next;

    logic                                out_vld_reg, out_vld_next;
    hkoc_pkg::status_t                   out_status_reg, out_status_next;
    logic [hkoc_pkg::OUT_COUNT_W-1:0]    out_count_reg, out_count_next;
    logic [hkoc_pkg::OUT_SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [hkoc_pkg::SUM_W-1:0]          out_sum_reg, out_sum_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] mix_const;
    logic [63:0] hash_val;
    logic        out_free;
    logic        ent_used;
    logic [63:0] ent_key;
    logic [COUNT_WIDTH-1:0] ent_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [31:0] sw_n;
    logic [32:0] sw_n1;
    logic [63:0] sum_add;
    logic [31:0] addr_wide;

    assign out_free  = !out_vld_reg || m_tready;
    assign mix_const = phase_reg ? hkoc_pkg::MIX_MUL_B : hkoc_pkg::MIX_MUL_A;
    assign hash_val  = acc_reg ^ (acc_reg >> hkoc_pkg::MIX_SHIFT_C);
    assign ent_used  = rd_data_reg[MEM_W-1];
    assign ent_key   = rd_data_reg[MEM_W-2 -: hkoc_pkg::KEY_W];
    assign ent_cnt   = rd_data_reg[COUNT_WIDTH-1:0];
    assign cnt_inc   = (ent_cnt == COUNT_MAX) ? ent_cnt : ent_cnt + COUNT_WIDTH'(1);
    assign addr_wide = 32'(addr_reg);

    assign sw_n  = ent_used ? 32'(ent_cnt) : 32'd0;
    assign sw_n1 = 33'(sw_n) + 33'd1;

    // n(n+1)/2 as (n/2)(n+1) or n((n+1)/2), so both operands fit in 32 bits
    always_comb begin
        if (rd_vld_reg) begin
            if (sw_n[0]) begin
                mul_a = sw_n;
                mul_b = sw_n1[32:1];
            end else begin
                mul_a = sw_n >> 1;
                mul_b = sw_n1[31:0];
            end
        end else begin
            case (step_reg)
                2'd0: begin
                    mul_a = a_reg[31:0];
                    mul_b = mix_const[31:0];
                end
                2'd1: begin
                    mul_a = a_reg[63:32];
                    mul_b = mix_const[31:0];
                end
                default: begin
                    mul_a = a_reg[31:0];
                    mul_b = mix_const[63:32];
                end
            endcase
        end
    end

    assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
    assign sum_add = 64'(sum_reg) + tri_reg;

    always_comb begin
        sum_next = sum_reg;
        if (tri_vld_reg) begin
            sum_next = sum_add[63] ? hkoc_pkg::SUM_MAX : sum_add[hkoc_pkg::SUM_W-1:0];
        end
        state_next      = state_reg;
        addr_next       = addr_reg;
        probe_next      = probe_reg;
        key_next        = key_reg;
        a_next          = a_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        rd_vld_next     = 1'b0;
        out_vld_next    = out_vld_reg && !m_tready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_slot_next   = out_slot_reg;
        out_sum_next    = out_sum_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = addr_reg;
        mem_wdata       = {1'b1, key_reg, COUNT_WIDTH'(1)};
        s_tready        = 1'b0;

        unique case (state_reg)
            hkoc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == ADDR_LAST) begin
                    state_next = hkoc_pkg::ST_IDLE;
                end
            end
            hkoc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == hkoc_pkg::REQ_READOUT) begin
                        addr_next  = '0;
                        sum_next   = '0;
                        state_next = hkoc_pkg::ST_SWEEP;
                    end else begin
                        key_next   = s_tdata;
                        a_next     = s_tdata ^ (s_tdata >> hkoc_pkg::MIX_SHIFT_A);
                        step_next  = 2'd0;
                        phase_next = 1'b0;
                        state_next = hkoc_pkg::ST_MUL;
                    end
                end
            end
            hkoc_pkg::ST_MUL: begin
                if (step_reg == 2'd0) begin
                    acc_next = prod;
                end else begin
                    acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2) begin
                    state_next = hkoc_pkg::ST_MIX;
                end
            end
            hkoc_pkg::ST_MIX: begin
                if (!phase_reg) begin
                    a_next     = acc_reg ^ (acc_reg >> hkoc_pkg::MIX_SHIFT_B);
                    phase_next = 1'b1;
                    step_next  = 2'd0;
                    state_next = hkoc_pkg::ST_MUL;
                end else begin
                    mem_addr   = hash_val[AW-1:0];
                    mem_re     = 1'b1;
                    addr_next  = hash_val[AW-1:0];
                    probe_next = '0;
                    state_next = hkoc_pkg::ST_PROBE;
                end
            end
            hkoc_pkg::ST_PROBE: begin
                if (out_free) begin
                    if (!ent_used) begin
                        mem_we          = 1'b1;
                        out_vld_next    = 1'b1;
                        out_status_next = hkoc_pkg::STATUS_NEW;
                        out_count_next  = 32'd1;
                        out_slot_next   = addr_wide[hkoc_pkg::OUT_SLOT_W-1:0];
                        out_sum_next    = '0;
                        state_next      = hkoc_pkg::ST_IDLE;
                    end else if (ent_key == key_reg) begin
                        mem_we          = 1'b1;
                        mem_wdata       = {1'b1, key_reg, cnt_inc};
                        out_vld_next    = 1'b1;
                        out_status_next = hkoc_pkg::STATUS_INC;
                        out_count_next  = 32'(cnt_inc);
                        out_slot_next   = addr_wide[hkoc_pkg::OUT_SLOT_W-1:0];
                        out_sum_next    = '0;
                        state_next      = hkoc_pkg::ST_IDLE;
                    end else if (probe_reg == ADDR_LAST) begin
                        out_vld_next    = 1'b1;
                        out_status_next = hkoc_pkg::STATUS_FULL;
                        out_count_next  = '0;
                        out_slot_next   = '0;
                        out_sum_next    = '0;
                        state_next      = hkoc_pkg::ST_IDLE;
                    end else begin
                        mem_addr   = addr_reg + AW'(1);
                        mem_re     = 1'b1;
                        addr_next  = addr_reg + AW'(1);
                        probe_next = probe_reg + AW'(1);
                    end
                end
            end
            hkoc_pkg::ST_SWEEP: begin
                mem_re      = 1'b1;
                rd_vld_next = 1'b1;
                addr_next   = addr_reg + AW'(1);
                if (addr_reg == ADDR_LAST) begin
                    state_next = hkoc_pkg::ST_DRAIN1;
                end
            end
            hkoc_pkg::ST_DRAIN1: begin
                state_next = hkoc_pkg::ST_DRAIN2;
            end
            hkoc_pkg::ST_DRAIN2: begin
                state_next = hkoc_pkg::ST_SW_OUT;
            end
            hkoc_pkg::ST_SW_OUT: begin
                if (out_free) begin
                    out_vld_next    = 1'b1;
                    out_status_next = hkoc_pkg::STATUS_READ;
                    out_count_next  = '0;
                    out_slot_next   = '0;
                    out_sum_next    = sum_reg;
                    state_next      = hkoc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hkoc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hkoc_pkg::ST_CLEAR;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            tri_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_vld_reg  <= rd_vld_next;
            tri_vld_reg <= rd_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg      <= probe_next;
        key_reg        <= key_next;
        a_reg          <= a_next;
        acc_reg        <= acc_next;
        step_reg       <= step_next;
        phase_reg      <= phase_next;
        tri_reg        <= prod;
        sum_reg        <= sum_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_slot_reg   <= out_slot_next;
        out_sum_reg    <= out_sum_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, out_sum_reg, out_slot_reg, out_count_reg};

    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("table memory written and read in one cycle");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hkoc_pkg::ST_CLEAR) |-> (mem_we && !s_tready))
        else $error("clearing pass must write and block requests");

    a_sum_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        tri_vld_reg |-> (state_reg == hkoc_pkg::ST_SWEEP
                         || state_reg == hkoc_pkg::ST_DRAIN1
                         || state_reg == hkoc_pkg::ST_DRAIN2))
        else $error("sum pipeline active outside a readout");

    a_new_count_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_status_reg == hkoc_pkg::STATUS_NEW)
            |-> (out_count_reg == 32'd1 && out_sum_reg == '0))
        else $error("new key must report count one");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_status_reg == hkoc_pkg::STATUS_FULL)
            |-> (out_count_reg == '0 && out_slot_reg == '0))
        else $error("table full result must carry zero fields");

endmodule
